>>> sv/ypr_pkg.sv
// shared widths, state codes and helpers for the yaw/pitch rotator
// used by every module of the block; depends on nothing
package ypr_pkg;

    localparam int QW    = 12;            // state, step and result width
    localparam int CW    = 11;            // limit register width
    localparam int QSH   = 10;            // q10 fraction bits
    localparam int MW    = 13;            // serial multiplier operand width
    localparam int PW    = 2 * MW;        // product width
    localparam int XW    = 27;            // turn sum width
    localparam int RW    = 28;            // square root radicand width
    localparam int SW    = RW / 2;        // root width
    localparam int QB    = 11;            // renormalized magnitude width
    localparam int DRW   = SW + 1;        // divider remainder width
    localparam int MCW   = $clog2(MW + 1);
    localparam int SCW   = $clog2(SW + 1);
    localparam int DCW   = $clog2(QB + 1);

    localparam logic REG_LIMIT_SINE   = 1'b0;
    localparam logic REG_LIMIT_COSINE = 1'b1;

    localparam logic [CW-1:0] LIMIT_SINE_RST   = CW'(887);
    localparam logic [CW-1:0] LIMIT_COSINE_RST = CW'(512);
    localparam logic [QW-1:0] Q_ONE            = QW'(1024);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_MUL_S,
        ST_TURN,
        ST_SQ_S,
        ST_SQ_C,
        ST_ROOT,
        ST_DIV_S,
        ST_DIV_C,
        ST_CLAMP,
        ST_OUT
    } ypr_state_t;

    function automatic logic [QW-1:0] mag_of(input logic [QW-1:0] v);
        return v[QW-1] ? QW'(-v) : v;
    endfunction

endpackage

>>> sv/ypr_smul.sv
// shift-add multiplier, one multiplier bit per cycle
// depends on ypr_pkg
module ypr_smul import ypr_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] a,
    input  logic [MW-1:0] b,
    output logic          done,
    output logic [PW-1:0] prod
);

    logic [MW-1:0]  mcand_reg;
    logic [PW-1:0]  prod_reg, prod_next;
    logic [MCW-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic [MW:0]    hi_sum;

    always_comb begin
        hi_sum    = {1'b0, prod_reg[PW-1:MW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {hi_sum, prod_reg[MW-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MCW'(MW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= a;
            prod_reg  <= {{MW{1'b0}}, b};
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

>>> sv/ypr_isqrt.sv
// floor integer square root, one root bit per cycle
// depends on ypr_pkg
module ypr_isqrt import ypr_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [RW-1:0] rad,
    output logic          done,
    output logic [SW-1:0] root
);

    logic [RW-1:0]  rad_reg;
    logic [SW+2:0]  rem_reg, rem_sh, trial;
    logic [SW-1:0]  root_reg;
    logic [SCW-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic           fits;

    always_comb begin
        rem_sh = {rem_reg[SW:0], rad_reg[RW-1:RW-2]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SCW'(SW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[SW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/ypr_sdiv.sv
// restoring divider for (num * 1024) / den with num <= den
// one quotient bit per cycle; depends on ypr_pkg
module ypr_sdiv import ypr_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] num,
    input  logic [SW-1:0] den,
    output logic          done,
    output logic [QB-1:0] quo
);

    logic [DRW-1:0] rem_reg, rem_sh;
    logic [SW-1:0]  den_reg;
    logic [QB-1:0]  bits_reg, quo_reg;
    logic [DCW-1:0] cnt_reg;
    logic           busy_reg, done_reg;
    logic           fits;

    always_comb begin
        rem_sh = {rem_reg[DRW-2:0], bits_reg[QB-1]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCW'(QB);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // upper dividend bits give num >> 1 with no quotient bits since num <= den
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= DRW'(num[MW-1:1]);
            bits_reg <= {num[0], {(QB-1){1'b0}}};
            den_reg  <= den;
            quo_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            bits_reg <= {bits_reg[QB-2:0], 1'b0};
            quo_reg  <= {quo_reg[QB-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> sv/yaw_pitch_incremental_rotator.sv
// top level: sequencer, state registers and stream ports of the rotator
// depends on ypr_pkg, ypr_smul, ypr_isqrt, ypr_sdiv
//
// usage: one request on s_ carries a yaw step and a pitch step; the block
// turns its stored yaw and pitch sine/cosine pairs (q10), renormalizes
// each pair, clamps pitch to the limit registers and returns the four new
// values as one result on m_.
// each pair uses the single shared serial multiplier for four products,
// then the serial square root and two serial divisions; a pair of zero
// length skips its divisions. one request is worked at a time.
// s_tready is high only while idle; a finished result sits in the output
// register, so the next request is taken while m_ is stalled, and the
// block waits at the end of that request until the register is free.
// reset: synchronous, active low; yaw and pitch return to sine 0 and
// cosine 1024, limits to 887 and 512. the user is to write the limits through
// cfg_wr_en/cfg_addr/cfg_wr_data only while the block is idle; it is not enforced.
module yaw_pitch_incremental_rotator import ypr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2*QW-1:0]   s_tdata,     // yaw_step, pitch_step
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [4*QW-1:0]   m_tdata,     // yaw_sine, yaw_cosine, pitch_sine, pitch_cosine
    input  logic              cfg_wr_en,
    input  logic              cfg_addr,
    input  logic [CW-1:0]     cfg_wr_data
);

    ypr_state_t state_reg, state_next;
    logic       first_reg;
    logic       pair_reg;

    logic [CW-1:0] lim_s_reg, lim_c_reg;
    logic [QW-1:0] ystep_reg, pstep_reg;
    logic [QW-1:0] yaw_sin_reg, yaw_cos_reg, pitch_sin_reg, pitch_cos_reg;
    logic [PW-1:0] prod_c_reg, prod_s_reg;
    logic [RW-1:0] sumsq_reg;
    logic [MW-1:0] nsm_reg, ncm_reg;
    logic          nsn_reg, ncn_reg;
    logic [4*QW-1:0] m_tdata_reg;
    logic          m_tvalid_reg;

    logic          mul_start, root_start, div_start;
    logic          mul_done, root_done, div_done;
    logic [MW-1:0] mul_a, mul_b, div_num;
    logic [PW-1:0] mul_prod;
    logic [SW-1:0] root;
    logic [QB-1:0] quo;

    logic [QW-1:0] cur_s, cur_c, cur_step;
    logic signed [XW-1:0] pcs, pss, xs, xc, xs_mag, xc_mag;
    logic [QW-1:0] div_val;
    logic          out_free;
    logic signed [QW-1:0] lim_s_pos, lim_s_neg, lim_c_val;

    ypr_smul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
    );

    ypr_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(root_start),
        .rad(sumsq_reg), .done(root_done), .root(root)
    );

    ypr_sdiv u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(root), .done(div_done), .quo(quo)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MUL_C;
            ST_MUL_C: if (mul_done) state_next = ST_MUL_S;
            ST_MUL_S: if (mul_done) state_next = ST_TURN;
            ST_TURN:  state_next = ST_SQ_S;
            ST_SQ_S:  if (mul_done) state_next = ST_SQ_C;
            ST_SQ_C:  if (mul_done) state_next = ST_ROOT;
            ST_ROOT: begin
                if (root_done) begin
                    if (root != '0) state_next = ST_DIV_S;
                    else            state_next = pair_reg ? ST_CLAMP : ST_MUL_C;
                end
            end
            ST_DIV_S: if (div_done) state_next = ST_DIV_C;
            ST_DIV_C: if (div_done) state_next = pair_reg ? ST_CLAMP : ST_MUL_C;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready   = 1'b0;
        mul_start  = 1'b0;
        root_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:                              s_tready = 1'b1;
            ST_MUL_C, ST_MUL_S, ST_SQ_S, ST_SQ_C: mul_start = first_reg;
            ST_ROOT:                              root_start = first_reg;
            ST_DIV_S, ST_DIV_C:                   div_start = first_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= state_next != state_reg;
        end
    end

    // operand selection
    always_comb begin
        cur_s    = pair_reg ? pitch_sin_reg : yaw_sin_reg;
        cur_c    = pair_reg ? pitch_cos_reg : yaw_cos_reg;
        cur_step = pair_reg ? pstep_reg : ystep_reg;
        case (state_reg)
            ST_MUL_C: begin
                mul_a = MW'(mag_of(cur_c));
                mul_b = MW'(mag_of(cur_step));
            end
            ST_MUL_S: begin
                mul_a = MW'(mag_of(cur_s));
                mul_b = MW'(mag_of(cur_step));
            end
            ST_SQ_S: begin
                mul_a = nsm_reg;
                mul_b = nsm_reg;
            end
            default: begin
                mul_a = ncm_reg;
                mul_b = ncm_reg;
            end
        endcase
        div_num = (state_reg == ST_DIV_S) ? nsm_reg : ncm_reg;
    end

    // small-angle turn, truncating toward zero
    always_comb begin
        pcs = $signed({1'b0, prod_c_reg});
        if (cur_c[QW-1] ^ cur_step[QW-1]) pcs = -pcs;
        pss = $signed({1'b0, prod_s_reg});
        if (cur_s[QW-1] ^ cur_step[QW-1]) pss = -pss;
        xs = $signed({{(XW-QW-QSH){cur_s[QW-1]}}, cur_s, {QSH{1'b0}}}) + pcs;
        xc = $signed({{(XW-QW-QSH){cur_c[QW-1]}}, cur_c, {QSH{1'b0}}}) - pss;
        xs_mag = xs[XW-1] ? -xs : xs;
        xc_mag = xc[XW-1] ? -xc : xc;
    end

    always_comb begin
        if (state_reg == ST_DIV_S) div_val = nsn_reg ? QW'(-{1'b0, quo}) : QW'({1'b0, quo});
        else                       div_val = ncn_reg ? QW'(-{1'b0, quo}) : QW'({1'b0, quo});
        lim_s_pos = $signed({1'b0, lim_s_reg});
        lim_s_neg = -lim_s_pos;
        lim_c_val = $signed({1'b0, lim_c_reg});
    end

    // limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_s_reg <= LIMIT_SINE_RST;
            lim_c_reg <= LIMIT_COSINE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LIMIT_SINE:   lim_s_reg <= cfg_wr_data;
                REG_LIMIT_COSINE: lim_c_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // direction state and pair select
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_sin_reg   <= '0;
            yaw_cos_reg   <= Q_ONE;
            pitch_sin_reg <= '0;
            pitch_cos_reg <= Q_ONE;
            pair_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: pair_reg <= 1'b0;
                ST_ROOT: begin
                    if (root_done && root == '0) begin
                        // zero length pair stays zero
                        if (pair_reg) begin
                            pitch_sin_reg <= '0;
                            pitch_cos_reg <= '0;
                        end else begin
                            yaw_sin_reg <= '0;
                            yaw_cos_reg <= '0;
                            pair_reg    <= 1'b1;
                        end
                    end
                end
                ST_DIV_S: begin
                    if (div_done) begin
                        if (pair_reg) pitch_sin_reg <= div_val;
                        else          yaw_sin_reg   <= div_val;
                    end
                end
                ST_DIV_C: begin
                    if (div_done) begin
                        if (pair_reg) begin
                            pitch_cos_reg <= div_val;
                        end else begin
                            yaw_cos_reg <= div_val;
                            pair_reg    <= 1'b1;
                        end
                    end
                end
                ST_CLAMP: begin
                    if ($signed(pitch_cos_reg) < lim_c_val) begin
                        pitch_sin_reg <= pitch_sin_reg[QW-1] ? lim_s_neg : lim_s_pos;
                        pitch_cos_reg <= lim_c_val;
                    end else if ($signed(pitch_sin_reg) > lim_s_pos) begin
                        pitch_sin_reg <= lim_s_pos;
                        pitch_cos_reg <= lim_c_val;
                    end else if ($signed(pitch_sin_reg) < lim_s_neg) begin
                        pitch_sin_reg <= lim_s_neg;
                        pitch_cos_reg <= lim_c_val;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ystep_reg <= s_tdata[QW-1:0];
                    pstep_reg <= s_tdata[2*QW-1:QW];
                end
            end
            ST_MUL_C: if (mul_done) prod_c_reg <= mul_prod;
            ST_MUL_S: if (mul_done) prod_s_reg <= mul_prod;
            ST_TURN: begin
                nsm_reg <= xs_mag[QSH +: MW];
                ncm_reg <= xc_mag[QSH +: MW];
                nsn_reg <= xs[XW-1];
                ncn_reg <= xc[XW-1];
            end
            ST_SQ_S: if (mul_done) sumsq_reg <= RW'(mul_prod);
            ST_SQ_C: if (mul_done) sumsq_reg <= sumsq_reg + RW'(mul_prod);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {pitch_cos_reg, pitch_sin_reg, yaw_cos_reg, yaw_sin_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
